### sv/peak_count_frequency_meter_core_assert.svh
// ----------------------------------------------------------------------------
// Peak count frequency meter assertion macros
// Concurrent check helpers shared by the meter RTL. They expect signals
// named clock and reset in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef PEAK_COUNT_FREQUENCY_METER_CORE_ASSERT_SVH
`define PEAK_COUNT_FREQUENCY_METER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PCFM_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pcfm same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PCFM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pcfm next-cycle check failed");

`endif

### sv/pcfm_pkg.sv
// ----------------------------------------------------------------------------
// Peak count frequency meter package
// Widths, register indexes, reset values and the structs passed between
// the meter datapath and the top level.
// ----------------------------------------------------------------------------
package pcfm_pkg;

   localparam int SAMPLE_BITS    = 12;
   localparam int COUNTER_BITS   = 16;
   localparam int NOISE_BITS     = 12;
   localparam int WINDOW_BITS    = 16;
   localparam int CHANGE_BITS    = 16;
   localparam int FREQ_BITS      = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [NOISE_BITS-1:0]   NOISE_MARGIN_RESET   = NOISE_BITS'(75);
   localparam logic [WINDOW_BITS-1:0]  WINDOW_SAMPLES_RESET = WINDOW_BITS'(1000);
   localparam logic [CHANGE_BITS-1:0]  CHANGE_MARGIN_RESET  = CHANGE_BITS'(10);
   localparam logic [SAMPLE_BITS-1:0]  AVERAGE_RESET        = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
   localparam logic [COUNTER_BITS-1:0] COUNTER_MAX          = {COUNTER_BITS{1'b1}};

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_NOISE_MARGIN   = 2'd0,
      CSR_WINDOW_SAMPLES = 2'd1,
      CSR_CHANGE_MARGIN  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [NOISE_BITS-1:0]  noise_margin;
      logic [WINDOW_BITS-1:0] window_samples;
      logic [CHANGE_BITS-1:0] change_margin;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] smoothed_level;
      logic                   peak_seen;
      logic                   frequency_valid;
      logic [FREQ_BITS-1:0]   frequency_value;
      logic                   frequency_changed;
   } result_type;

endpackage

### sv/pcfm_meter.sv
// ----------------------------------------------------------------------------
// Peak count frequency meter datapath
// Holds the smoothing, peak detection and counter state and computes one
// result per sample in a single pass. State advances on each step.
// ----------------------------------------------------------------------------
module pcfm_meter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [pcfm_pkg::SAMPLE_BITS-1:0] sample,
   input  pcfm_pkg::cfg_type              cfg,
   output pcfm_pkg::result_type           result
);
   import pcfm_pkg::*;

   logic [SAMPLE_BITS-1:0]  average_ff, average_in;
   logic [SAMPLE_BITS-1:0]  prev_average_ff, prev_average_in;
   logic                    rising_ff, rising_in;
   logic [COUNTER_BITS-1:0] sample_count_ff, sample_count_in;
   logic [COUNTER_BITS-1:0] peak_count_ff, peak_count_in;
   logic [COUNTER_BITS-1:0] base_freq_ff, base_freq_in;
   logic [COUNTER_BITS-1:0] published_ff, published_in;

   logic [SAMPLE_BITS:0]    avg_sum;
   logic                    rise;
   logic                    fall;
   logic                    publish;
   logic                    changed;
   logic [COUNTER_BITS-1:0] freq_diff;
   logic [COUNTER_BITS-1:0] sample_inc;
   logic [COUNTER_BITS-1:0] peak_inc;

   always_comb begin
      // quarter-weight moving average; the sum never exceeds full scale
      avg_sum    = {1'b0, sample >> 2} + {1'b0, average_ff - (average_ff >> 2)};
      average_in = avg_sum[SAMPLE_BITS-1:0];

      rise = {1'b0, average_in} > ({1'b0, prev_average_ff} + {1'b0, cfg.noise_margin});
      fall = !rise && rising_ff &&
             (({1'b0, average_in} + {1'b0, cfg.noise_margin}) < {1'b0, prev_average_ff});

      publish = fall && (sample_count_ff >= COUNTER_BITS'(cfg.window_samples));

      freq_diff = (peak_count_ff > base_freq_ff) ? peak_count_ff - base_freq_ff
                                                 : base_freq_ff - peak_count_ff;
      changed   = publish && (freq_diff > COUNTER_BITS'(cfg.change_margin));

      sample_inc = (sample_count_ff == COUNTER_MAX) ? COUNTER_MAX
                                                    : sample_count_ff + COUNTER_BITS'(1);
      peak_inc   = (peak_count_ff == COUNTER_MAX) ? COUNTER_MAX
                                                  : peak_count_ff + COUNTER_BITS'(1);

      // a publishing peak restarts both counts, then counts itself
      sample_count_in = publish ? COUNTER_BITS'(1) : sample_inc;
      if (publish) begin
         peak_count_in = COUNTER_BITS'(1);
      end else if (fall) begin
         peak_count_in = peak_inc;
      end else begin
         peak_count_in = peak_count_ff;
      end

      rising_in       = rise | (rising_ff & !fall);
      published_in    = publish ? peak_count_ff : published_ff;
      base_freq_in    = changed ? peak_count_ff : base_freq_ff;
      prev_average_in = average_in;

      result.smoothed_level    = average_in;
      result.peak_seen         = fall;
      result.frequency_valid   = publish;
      result.frequency_value   = published_in[FREQ_BITS-1:0];
      result.frequency_changed = changed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         average_ff      <= AVERAGE_RESET;
         prev_average_ff <= '0;
         rising_ff       <= 1'b0;
         sample_count_ff <= '0;
         peak_count_ff   <= '0;
         base_freq_ff    <= '0;
         published_ff    <= '0;
      end else if (step) begin
         average_ff      <= average_in;
         prev_average_ff <= prev_average_in;
         rising_ff       <= rising_in;
         sample_count_ff <= sample_count_in;
         peak_count_ff   <= peak_count_in;
         base_freq_ff    <= base_freq_in;
         published_ff    <= published_in;
      end
   end

endmodule

### sv/peak_count_frequency_meter_core.sv
// ----------------------------------------------------------------------------
// Peak count frequency meter core
// Smooths a stream of converter samples, counts peaks and publishes the
// peak count per sample window as a frequency, flagging large changes.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one 12-bit sample per transfer. Each accepted sample
//   produces exactly one rsp_ transfer with the smoothed level, peak flag,
//   publish flag, held frequency value and change flag.
//   A sample accepted on req_ is registered and shown on rsp_ from the next
//   cycle. Throughput is one sample per cycle while the receiver takes each
//   result; the whole update is a single pass through the meter state registers.
//   The result sits in an output register. While it waits, a new sample is
//   taken in the same cycle that the receiver takes the waiting result; if the
//   receiver stalls, req_ready drops until the result is taken.
//   csr_ channel writes noise margin (index 0), window length (index 1) and
//   change margin (index 2); other indexes are ignored. Write only when idle.
//   Synchronous reset restores the register defaults (75, 1000, 10), sets the
//   average to mid-scale, clears all counters and drops rsp_valid.
// ----------------------------------------------------------------------------
module peak_count_frequency_meter_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [pcfm_pkg::SAMPLE_BITS-1:0]   req_adc_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [pcfm_pkg::SAMPLE_BITS-1:0]   rsp_smoothed_level,
   output logic                               rsp_peak_seen,
   output logic                               rsp_frequency_valid,
   output logic [pcfm_pkg::FREQ_BITS-1:0]     rsp_frequency_value,
   output logic                               rsp_frequency_changed,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pcfm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [pcfm_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import pcfm_pkg::*;

   `include "peak_count_frequency_meter_core_assert.svh"

   cfg_type    cfg_ff, cfg_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_result_ff;
   result_type result;
   logic       req_transfer;
   logic       csr_transfer;

   assign req_ready    = !reset && (!rsp_valid_ff || rsp_ready);
   assign req_transfer = req_valid && req_ready;
   assign csr_ready    = !reset;
   assign csr_transfer = csr_valid && csr_ready;

   pcfm_meter u_meter (
      .clock  (clock),
      .reset  (reset),
      .step   (req_transfer),
      .sample (req_adc_sample),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_transfer) begin
         case (csr_index_type'(csr_index))
            CSR_NOISE_MARGIN:   cfg_in.noise_margin   = csr_data[NOISE_BITS-1:0];
            CSR_WINDOW_SAMPLES: cfg_in.window_samples = csr_data[WINDOW_BITS-1:0];
            CSR_CHANGE_MARGIN:  cfg_in.change_margin  = csr_data[CHANGE_BITS-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // hold the result until taken; refill in the same cycle it drains
   assign rsp_valid_in = req_transfer || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.noise_margin   <= NOISE_MARGIN_RESET;
         cfg_ff.window_samples <= WINDOW_SAMPLES_RESET;
         cfg_ff.change_margin  <= CHANGE_MARGIN_RESET;
         rsp_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_smoothed_level    = rsp_result_ff.smoothed_level;
   assign rsp_peak_seen         = rsp_result_ff.peak_seen;
   assign rsp_frequency_valid   = rsp_result_ff.frequency_valid;
   assign rsp_frequency_value   = rsp_result_ff.frequency_value;
   assign rsp_frequency_changed = rsp_result_ff.frequency_changed;

   `PCFM_ASSERT_NEXT(a_accept_fills_rsp, req_transfer, rsp_valid_ff)
   `PCFM_ASSERT_SAME(a_no_overwrite, rsp_valid_ff && !rsp_ready, !req_ready)
   `PCFM_ASSERT_SAME(a_publish_on_peak, rsp_valid_ff && rsp_frequency_valid, rsp_peak_seen)
   `PCFM_ASSERT_SAME(a_change_on_publish, rsp_valid_ff && rsp_frequency_changed,
                     rsp_frequency_valid)

endmodule

### tb/sv/tb_peak_count_frequency_meter_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Peak count frequency meter core testbench
// Streams converter samples into the meter and checks every result against
// an in-bench model of the smoothing, peak detection and frequency publishing.
// Directed samples cover the range ends and register corners. Random phases
// then mix idle patterns on both channels with square-wave bursts and noise.
// A short closing run checks peaks against the widest window.
// ----------------------------------------------------------------------------
module tb_peak_count_frequency_meter_core;
   import pcfm_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 2'd3;
   localparam int HOLD_OFF_CYCLES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [SAMPLE_BITS-1:0] req_adc_sample = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [SAMPLE_BITS-1:0] rsp_smoothed_level;
   logic rsp_peak_seen;
   logic rsp_frequency_valid;
   logic [FREQ_BITS-1:0] rsp_frequency_value;
   logic rsp_frequency_changed;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   // meter model state and register copy
   cfg_type meter_cfg;
   logic [SAMPLE_BITS-1:0] avg_level;
   logic [SAMPLE_BITS-1:0] prev_level;
   logic climbing;
   logic [COUNTER_BITS-1:0] samples_in_window;
   logic [COUNTER_BITS-1:0] peaks_in_window;
   logic [COUNTER_BITS-1:0] base_freq;
   logic [COUNTER_BITS-1:0] published_freq;

   logic [SAMPLE_BITS-1:0] pending_samples[$];
   result_type expected_results[$];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_off_requests = 0;
   int hold_off_served = 0;
   int hold_off_left = 0;
   int failures = 0;
   int samples_accepted = 0;
   int peaks_reported = 0;
   int publishes_reported = 0;
   int changes_reported = 0;
   int settings_used = 0;

   peak_count_frequency_meter_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_adc_sample        (req_adc_sample),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_smoothed_level    (rsp_smoothed_level),
      .rsp_peak_seen         (rsp_peak_seen),
      .rsp_frequency_valid   (rsp_frequency_valid),
      .rsp_frequency_value   (rsp_frequency_value),
      .rsp_frequency_changed (rsp_frequency_changed),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Advance the meter model by one sample and return what the block must show.
   function automatic result_type predict_meter(logic [SAMPLE_BITS-1:0] sample);
      result_type r;
      int unsigned lvl;
      int unsigned last;
      int unsigned margin;
      int unsigned gap;
      r = '0;
      avg_level = (sample >> 2) + (avg_level - (avg_level >> 2));
      lvl = avg_level;
      last = prev_level;
      margin = meter_cfg.noise_margin;
      // compare at full width so a large margin never wraps
      if (lvl > last + margin) begin
         climbing = 1'b1;
      end else if (climbing && lvl + margin < last) begin
         climbing = 1'b0;
         r.peak_seen = 1'b1;
         if (samples_in_window >= meter_cfg.window_samples) begin
            samples_in_window = '0;
            published_freq = peaks_in_window;
            r.frequency_valid = 1'b1;
            gap = (peaks_in_window > base_freq) ? peaks_in_window - base_freq
                                                : base_freq - peaks_in_window;
            if (gap > meter_cfg.change_margin) begin
               r.frequency_changed = 1'b1;
               base_freq = peaks_in_window;
            end
            peaks_in_window = '0;
         end
         // the peak that closed the window opens the next one
         if (peaks_in_window != COUNTER_MAX) peaks_in_window++;
      end
      if (samples_in_window != COUNTER_MAX) samples_in_window++;
      prev_level = avg_level;
      r.smoothed_level = avg_level;
      r.frequency_value = published_freq;
      return r;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         failures++;
      end
   endtask

   // Sample driver: log accepted samples into the model, then offer the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(predict_meter(req_adc_sample));
            samples_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_adc_sample <= pending_samples.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result receiver: random stalls plus an occasional long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off_requests != hold_off_served) begin
         hold_off_served = hold_off_requests;
         hold_off_left = HOLD_OFF_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Result monitor
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result transfer, expected none, actual level %0d",
                     $time, rsp_smoothed_level);
            failures++;
         end else begin
            want = expected_results.pop_front();
            check_field("smoothed_level", want.smoothed_level, rsp_smoothed_level);
            check_field("peak_seen", want.peak_seen, rsp_peak_seen);
            check_field("frequency_valid", want.frequency_valid, rsp_frequency_valid);
            check_field("frequency_value", want.frequency_value, rsp_frequency_value);
            check_field("frequency_changed", want.frequency_changed,
                        rsp_frequency_changed);
         end
         peaks_reported += rsp_peak_seen;
         publishes_reported += rsp_frequency_valid;
         changes_reported += rsp_frequency_changed;
      end
   end

   task automatic wait_until_drained();
      while (pending_samples.size() != 0 || expected_results.size() != 0 || req_valid)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // Write one register while the meter is idle and mirror it in the model.
   task automatic write_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      case (index)
         CSR_NOISE_MARGIN:   meter_cfg.noise_margin = value[NOISE_BITS-1:0];
         CSR_WINDOW_SAMPLES: meter_cfg.window_samples = value;
         CSR_CHANGE_MARGIN:  meter_cfg.change_margin = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Mostly square-wave bursts with random levels, period and noise; some pure noise.
   task automatic queue_signal(int count);
      int half;
      int low;
      int high;
      int noise;
      int span;
      int v;
      while (count > 0) begin
         span = $urandom_range(8, 60);
         if ($urandom_range(4) == 0) begin
            for (int i = 0; i < span && count > 0; i++, count--)
               pending_samples.push_back(SAMPLE_BITS'($urandom_range(4095)));
         end else begin
            half = $urandom_range(1, 12);
            low = $urandom_range(0, 2047);
            high = $urandom_range(low, 4095);
            noise = $urandom_range(0, 64);
            for (int i = 0; i < span && count > 0; i++, count--) begin
               v = (((i / half) % 2) ? low : high) + $urandom_range(0, noise);
               if (v > 4095) v = 4095;
               pending_samples.push_back(SAMPLE_BITS'(v));
            end
         end
      end
   endtask

   initial begin
      int lvl;
      int directed[$];
      meter_cfg.noise_margin = NOISE_MARGIN_RESET;
      meter_cfg.window_samples = WINDOW_SAMPLES_RESET;
      meter_cfg.change_margin = CHANGE_MARGIN_RESET;
      avg_level = AVERAGE_RESET;
      prev_level = '0;
      climbing = 1'b0;
      samples_in_window = '0;
      peaks_in_window = '0;
      base_freq = '0;
      published_freq = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // range ends and a clean rise and fall at the reset settings
      settings_used++;
      directed = '{0, 4095, 4095, 4095, 0, 0, 0, 0, 2048, 1, 4094, 2730};
      foreach (directed[i])
         pending_samples.push_back(SAMPLE_BITS'(directed[i]));
      wait_until_drained();

      // zero margins and a zero window: every peak publishes a frequency
      write_register(CSR_NOISE_MARGIN, 16'h0000);
      write_register(CSR_WINDOW_SAMPLES, 16'h0000);
      write_register(CSR_CHANGE_MARGIN, 16'h0000);
      write_register(CSR_UNMAPPED, 16'hFFFF);
      settings_used++;
      directed = '{4095, 0, 4095, 0, 4095, 0, 4095, 0, 3000, 1000};
      foreach (directed[i])
         pending_samples.push_back(SAMPLE_BITS'(directed[i]));
      wait_until_drained();

      // widest margins: upper data bits of the noise margin drop, nothing triggers
      write_register(CSR_NOISE_MARGIN, 16'hFFFF);
      write_register(CSR_WINDOW_SAMPLES, 16'hFFFF);
      write_register(CSR_CHANGE_MARGIN, 16'hFFFF);
      settings_used++;
      directed = '{0, 4095, 0, 4095};
      foreach (directed[i])
         pending_samples.push_back(SAMPLE_BITS'(directed[i]));
      wait_until_drained();

      for (int phase = 0; phase < 8; phase++) begin
         case ($urandom_range(9))
            0: lvl = 0;
            1: lvl = 4095;
            default: lvl = $urandom_range(8, 200);
         endcase
         write_register(CSR_NOISE_MARGIN, {4'($urandom), 12'(lvl)});
         case ($urandom_range(9))
            0: lvl = 0;
            1: lvl = 65535;
            default: lvl = $urandom_range(1, 120);
         endcase
         write_register(CSR_WINDOW_SAMPLES, CSR_DATA_BITS'(lvl));
         case ($urandom_range(9))
            0: lvl = 0;
            1: lvl = 65535;
            default: lvl = $urandom_range(0, 12);
         endcase
         write_register(CSR_CHANGE_MARGIN, CSR_DATA_BITS'(lvl));
         settings_used++;
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 69; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 69; end
            default: begin sender_idle_pct = 14; receiver_stall_pct = 14; end
         endcase
         // fill the block against a stalled receiver
         if (phase == 4) hold_off_requests++;
         queue_signal(120);
         // let the whole pipeline empty before the rest of the phase
         if (phase == 1) wait_until_drained();
         queue_signal(120);
         wait_until_drained();
      end

      // full swings against the widest window: peaks count, nothing publishes
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      write_register(CSR_NOISE_MARGIN, 16'h0000);
      write_register(CSR_WINDOW_SAMPLES, 16'hFFFF);
      write_register(CSR_CHANGE_MARGIN, 16'h0000);
      settings_used++;
      directed = '{0, 4095, 0, 4095, 0, 4095, 0};
      foreach (directed[i])
         pending_samples.push_back(SAMPLE_BITS'(directed[i]));
      wait_until_drained();

      repeat (10) @(negedge clock);
      $display("covered %0d samples over %0d register settings with four idle patterns",
               samples_accepted, settings_used);
      $display("results showed %0d peaks, %0d frequency updates, %0d changes",
               peaks_reported, publishes_reported, changes_reported);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("status: fail");
      $finish;
   end

endmodule
